// ===== rtl/oriented_rect_occlusion_test_unit_assert.svh =====
// ----------------------------------------------------------------------------
// oriented_rect_occlusion_test_unit_assert.svh
// assertion macros used by orot_ctrl; clk and rst_n must be in scope
// ----------------------------------------------------------------------------
`ifndef ORIENTED_RECT_OCCLUSION_TEST_UNIT_ASSERT_SVH
`define ORIENTED_RECT_OCCLUSION_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define OROT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OROT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/orot_pkg.sv =====
// ----------------------------------------------------------------------------
// orot_pkg
// types, constants, sine table and card microprogram of the occlusion test
// ----------------------------------------------------------------------------
package orot_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int KEY_W   = 16;
  localparam int ORDER_W = 4 * KEY_W;

  // request codes
  localparam logic REQ_MARKER = 1'b0;
  localparam logic REQ_CARD   = 1'b1;

  // sine table geometry (depth is a power of two)
  localparam int TRIG_DEPTH = 256;
  localparam int TRIG_AW    = $clog2(TRIG_DEPTH);
  localparam int STEP_W     = TRIG_AW + 2;
  localparam int TRIG_VAL_W = 17;
  localparam int TRIG_W     = TRIG_VAL_W + 1;

  // datapath widths
  localparam int DELTA_W = COORD_W + 2;
  localparam int MUL_A_W = DELTA_W + 1;
  localparam int MUL_B_W = COORD_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DOT_W   = 18;

  // table generation constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 10;
  localparam logic [63:0] TAYLOR_DIV [0:TAYLOR_TERMS-1] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
      64'd420};

  typedef logic [TRIG_VAL_W-1:0] sine_rom_t [0:TRIG_DEPTH];

  // quarter-wave sine in q1.16, taylor series in q2.30 with truncation
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= TRIG_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / TRIG_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) begin
        sum = 65536;
      end
      rom[k] = TRIG_VAL_W'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // input transaction payload
  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        size_w;
    logic [COORD_W-1:0]        size_h;
    logic [ANGLE_W-1:0]        angle;
    logic signed [KEY_W-1:0]   layer_priority;
    logic signed [KEY_W-1:0]   z_order;
    logic [KEY_W-1:0]          child_index;
    logic [KEY_W-1:0]          stable_index;
    logic                      last;
  } in_item_t;

  // microprogram encoding
  typedef enum logic [1:0] {OP_NOP, OP_MUL, OP_ROUND, OP_CMP} op_kind_t;
  typedef enum logic [3:0] {
    A_C1, A_S1, A_C2, A_S2, A_DX, A_DY, A_N1, A_N2, A_P, A_Q
  } a_sel_t;
  typedef enum logic [2:0] {
    B_C1, B_S1, B_C2, B_S2, B_HW1, B_HH1, B_HW2, B_HH2
  } b_sel_t;
  typedef enum logic [3:0] {
    ACC_N1, ACC_N2, ACC_P, ACC_Q, ACC_D0, ACC_D1, ACC_D2, ACC_D3,
    ACC_R0, ACC_R1, ACC_R2, ACC_R3
  } acc_sel_t;
  localparam int ACC_NUM = 12;

  typedef struct packed {
    op_kind_t kind;
    a_sel_t   a_sel;
    b_sel_t   b_sel;
    acc_sel_t dest;
    logic     neg;
  } uop_t;

  localparam uop_t UOP_NOP = '{OP_NOP, A_C1, B_C1, ACC_N1, 1'b0};

  // card test program: axis dots, round, distances, radii, compare
  localparam int PROG_LEN = 32;
  localparam int PC_W     = $clog2(PROG_LEN);
  localparam uop_t PROG [0:PROG_LEN-1] = '{
    '{OP_MUL,   A_C1, B_C1,  ACC_N1, 1'b0},
    '{OP_MUL,   A_S1, B_S1,  ACC_N1, 1'b0},
    '{OP_MUL,   A_C2, B_C2,  ACC_N2, 1'b0},
    '{OP_MUL,   A_S2, B_S2,  ACC_N2, 1'b0},
    '{OP_MUL,   A_C1, B_C2,  ACC_P,  1'b0},
    '{OP_MUL,   A_S1, B_S2,  ACC_P,  1'b0},
    '{OP_MUL,   A_S1, B_C2,  ACC_Q,  1'b0},
    '{OP_MUL,   A_C1, B_S2,  ACC_Q,  1'b1},
    '{OP_NOP,   A_C1, B_C1,  ACC_N1, 1'b0},
    '{OP_ROUND, A_C1, B_C1,  ACC_N1, 1'b0},
    '{OP_MUL,   A_DX, B_C1,  ACC_D0, 1'b0},
    '{OP_MUL,   A_DY, B_S1,  ACC_D0, 1'b0},
    '{OP_MUL,   A_DX, B_S1,  ACC_D1, 1'b1},
    '{OP_MUL,   A_DY, B_C1,  ACC_D1, 1'b0},
    '{OP_MUL,   A_DX, B_C2,  ACC_D2, 1'b0},
    '{OP_MUL,   A_DY, B_S2,  ACC_D2, 1'b0},
    '{OP_MUL,   A_DX, B_S2,  ACC_D3, 1'b1},
    '{OP_MUL,   A_DY, B_C2,  ACC_D3, 1'b0},
    '{OP_MUL,   A_N1, B_HW1, ACC_R0, 1'b0},
    '{OP_MUL,   A_P,  B_HW2, ACC_R0, 1'b0},
    '{OP_MUL,   A_Q,  B_HH2, ACC_R0, 1'b0},
    '{OP_MUL,   A_N1, B_HH1, ACC_R1, 1'b0},
    '{OP_MUL,   A_Q,  B_HW2, ACC_R1, 1'b0},
    '{OP_MUL,   A_P,  B_HH2, ACC_R1, 1'b0},
    '{OP_MUL,   A_P,  B_HW1, ACC_R2, 1'b0},
    '{OP_MUL,   A_Q,  B_HH1, ACC_R2, 1'b0},
    '{OP_MUL,   A_N2, B_HW2, ACC_R2, 1'b0},
    '{OP_MUL,   A_Q,  B_HW1, ACC_R3, 1'b0},
    '{OP_MUL,   A_P,  B_HH1, ACC_R3, 1'b0},
    '{OP_MUL,   A_N2, B_HH2, ACC_R3, 1'b0},
    '{OP_NOP,   A_C1, B_C1,  ACC_N1, 1'b0},
    '{OP_CMP,   A_C1, B_C1,  ACC_N1, 1'b0}
  };

  // controller to datapath
  typedef struct packed {
    logic load_marker;
    logic load_card;
    uop_t uop;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
  } dp_stat_t;

endpackage

// ===== rtl/orot_in_if.sv =====
// ----------------------------------------------------------------------------
// orot_in_if
// request channel: marker and card rectangles with order keys
// ----------------------------------------------------------------------------
interface orot_in_if;
  import orot_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [COORD_W-1:0]        size_w;
  logic [COORD_W-1:0]        size_h;
  logic [ANGLE_W-1:0]        angle;
  logic signed [KEY_W-1:0]   layer_priority;
  logic signed [KEY_W-1:0]   z_order;
  logic [KEY_W-1:0]          child_index;
  logic [KEY_W-1:0]          stable_index;
  logic                      last;

  modport source (
    output valid, req_type, center_x, center_y, size_w, size_h, angle,
           layer_priority, z_order, child_index, stable_index, last,
    input  ready
  );
  modport sink (
    input  valid, req_type, center_x, center_y, size_w, size_h, angle,
           layer_priority, z_order, child_index, stable_index, last,
    output ready
  );
endinterface

// ===== rtl/orot_out_if.sv =====
// ----------------------------------------------------------------------------
// orot_out_if
// result channel: one occlusion flag per list
// ----------------------------------------------------------------------------
interface orot_out_if;
  logic valid;
  logic ready;
  logic occluded;

  modport source (output valid, occluded, input ready);
  modport sink (input valid, occluded, output ready);
endinterface

// ===== rtl/orot_datapath.sv =====
// ----------------------------------------------------------------------------
// orot_datapath
// query store, trig lookup, shared multiplier with accumulators, axis compare
// ----------------------------------------------------------------------------
module orot_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  orot_pkg::in_item_t item,
  input  orot_pkg::dp_cmd_t  cmd,
  output orot_pkg::dp_stat_t stat
);
  import orot_pkg::*;

  typedef struct packed {
    logic     valid;
    acc_sel_t dest;
    logic     neg;
  } pend_t;

  // query rectangle
  logic signed [COORD_W-1:0] qcx_r, qcy_r;
  logic [COORD_W-1:0]        qhw_r, qhh_r;
  logic signed [TRIG_W-1:0]  qcos_r, qsin_r;
  logic [ORDER_W-1:0]        qkey_r;

  // card under test
  logic signed [TRIG_W-1:0]  c2_r, s2_r;
  logic [COORD_W-1:0]        hw2_r, hh2_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic                      key_gt_r, size_ok_r;

  // rounded axis dots
  logic [DOT_W-1:0] n1_r, n2_r, p_r, q_r;

  // multiplier and accumulators
  logic signed [PROD_W-1:0] prod_r;
  pend_t                    pend_r;
  logic signed [PROD_W-1:0] acc_r [0:ACC_NUM-1];

  logic [STEP_W-1:0]         trig_step;
  logic [TRIG_AW-1:0]        trig_pos;
  logic [1:0]                trig_quad;
  logic signed [TRIG_W-1:0]  sa, sb, in_cos, in_sin;
  logic [ORDER_W-1:0]        in_key;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic signed [MUL_A_W-1:0] opa;
  logic signed [MUL_B_W-1:0] opb;
  logic [3:0]                sep;

  function automatic logic [DOT_W-1:0] round_dot(logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    mag = (v < 0) ? PROD_W'(-v) : PROD_W'(v);
    mag = mag + PROD_W'(32768);
    return mag[16 +: DOT_W];
  endfunction

  function automatic logic separated(logic signed [PROD_W-1:0] d,
                                     logic signed [PROD_W-1:0] r);
    logic [PROD_W-1:0] mag;
    mag = (d < 0) ? PROD_W'(-d) : PROD_W'(d);
    return mag > PROD_W'(r);
  endfunction

  // sine/cosine of the incoming angle by quadrant folding
  always_comb begin
    trig_step = item.angle[ANGLE_W-1 -: STEP_W];
    trig_pos  = trig_step[TRIG_AW-1:0];
    trig_quad = trig_step[STEP_W-1 -: 2];
    sa = $signed({1'b0, SINE_ROM[{1'b0, trig_pos}]});
    sb = $signed({1'b0, SINE_ROM[(TRIG_AW+1)'(TRIG_DEPTH) - {1'b0, trig_pos}]});
    case (trig_quad)
      2'd0: begin in_sin = sa;  in_cos = sb;  end
      2'd1: begin in_sin = sb;  in_cos = -sa; end
      2'd2: begin in_sin = -sa; in_cos = -sb; end
      default: begin in_sin = -sb; in_cos = sa; end
    endcase
  end

  // packed order key and centre deltas
  assign in_key = {item.layer_priority ^ 16'h8000, item.z_order ^ 16'h8000,
                   item.child_index, item.stable_index};
  assign diff_x = (COORD_W+1)'($signed(item.center_x)) - (COORD_W+1)'(qcx_r);
  assign diff_y = (COORD_W+1)'($signed(item.center_y)) - (COORD_W+1)'(qcy_r);

  // query store, reset to an empty rectangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcx_r  <= '0;
      qcy_r  <= '0;
      qhw_r  <= '0;
      qhh_r  <= '0;
      qcos_r <= '0;
      qsin_r <= '0;
      qkey_r <= '0;
    end else if (cmd.load_marker) begin
      qcx_r  <= item.center_x;
      qcy_r  <= item.center_y;
      qhw_r  <= item.size_w;
      qhh_r  <= item.size_h;
      qcos_r <= in_cos;
      qsin_r <= in_sin;
      qkey_r <= in_key;
    end
  end

  // card capture
  always_ff @(posedge clk) begin
    if (cmd.load_card) begin
      c2_r      <= in_cos;
      s2_r      <= in_sin;
      hw2_r     <= item.size_w;
      hh2_r     <= item.size_h;
      dx_r      <= {diff_x, 1'b0};
      dy_r      <= {diff_y, 1'b0};
      key_gt_r  <= in_key > qkey_r;
      size_ok_r <= (qhw_r != '0) && (qhh_r != '0) && (item.size_w != '0) &&
                   (item.size_h != '0);
    end
  end

  // operand selection
  always_comb begin
    case (cmd.uop.a_sel)
      A_C1:    opa = MUL_A_W'(qcos_r);
      A_S1:    opa = MUL_A_W'(qsin_r);
      A_C2:    opa = MUL_A_W'(c2_r);
      A_S2:    opa = MUL_A_W'(s2_r);
      A_DX:    opa = MUL_A_W'(dx_r);
      A_DY:    opa = MUL_A_W'(dy_r);
      A_N1:    opa = MUL_A_W'($signed({1'b0, n1_r}));
      A_N2:    opa = MUL_A_W'($signed({1'b0, n2_r}));
      A_P:     opa = MUL_A_W'($signed({1'b0, p_r}));
      A_Q:     opa = MUL_A_W'($signed({1'b0, q_r}));
      default: opa = '0;
    endcase
    case (cmd.uop.b_sel)
      B_C1:    opb = MUL_B_W'(qcos_r);
      B_S1:    opb = MUL_B_W'(qsin_r);
      B_C2:    opb = MUL_B_W'(c2_r);
      B_S2:    opb = MUL_B_W'(s2_r);
      B_HW1:   opb = $signed({1'b0, qhw_r});
      B_HH1:   opb = $signed({1'b0, qhh_r});
      B_HW2:   opb = $signed({1'b0, hw2_r});
      B_HH2:   opb = $signed({1'b0, hh2_r});
      default: opb = '0;
    endcase
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r.valid <= (cmd.uop.kind == OP_MUL);
      pend_r.dest  <= cmd.uop.dest;
      pend_r.neg   <= cmd.uop.neg;
    end
    prod_r <= opa * opb;
  end

  // accumulate stage, cleared at each card
  always_ff @(posedge clk) begin
    if (cmd.load_card) begin
      for (int i = 0; i < ACC_NUM; i++) begin
        acc_r[i] <= '0;
      end
    end else if (pend_r.valid) begin
      acc_r[pend_r.dest] <= pend_r.neg ? acc_r[pend_r.dest] - prod_r :
                                         acc_r[pend_r.dest] + prod_r;
    end
  end

  // rounded axis dots
  always_ff @(posedge clk) begin
    if (cmd.uop.kind == OP_ROUND) begin
      n1_r <= round_dot(acc_r[ACC_N1]);
      n2_r <= round_dot(acc_r[ACC_N2]);
      p_r  <= round_dot(acc_r[ACC_P]);
      q_r  <= round_dot(acc_r[ACC_Q]);
    end
  end

  // separating-axis decision
  always_comb begin
    sep[0] = separated(acc_r[ACC_D0], acc_r[ACC_R0]);
    sep[1] = separated(acc_r[ACC_D1], acc_r[ACC_R1]);
    sep[2] = separated(acc_r[ACC_D2], acc_r[ACC_R2]);
    sep[3] = separated(acc_r[ACC_D3], acc_r[ACC_R3]);
    stat.hit = (cmd.uop.kind == OP_CMP) && key_gt_r && size_ok_r && (sep == '0);
  end

endmodule

// ===== rtl/orot_ctrl.sv =====
// ----------------------------------------------------------------------------
// orot_ctrl
// sequencer: accepts transactions, steps the card program, emits the result
// ----------------------------------------------------------------------------
module orot_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_occluded,
  output orot_pkg::dp_cmd_t  cmd,
  input  orot_pkg::dp_stat_t stat
);
  import orot_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  localparam logic [PC_W-1:0] STEP_LAST = PC_W'(PROG_LEN - 1);

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] step_r, step_nxt;
  logic            last_r, last_nxt;
  logic            hit_seen_r, hit_seen_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            occluded_r, occluded_nxt;
  logic            accept;

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_occluded = occluded_r;

  // datapath commands
  always_comb begin
    cmd.load_marker = accept && (in_req_type == REQ_MARKER);
    cmd.load_card   = accept && (in_req_type == REQ_CARD);
    cmd.uop         = (state_r == S_RUN) ? PROG[step_r] : UOP_NOP;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    hit_seen_nxt  = hit_seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    occluded_nxt  = occluded_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          if (in_req_type == REQ_MARKER) begin
            hit_seen_nxt = 1'b0;
            state_nxt    = in_last ? S_EMIT : S_IDLE;
          end else begin
            step_nxt  = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          hit_seen_nxt = hit_seen_r || stat.hit;
          state_nxt    = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          occluded_nxt  = hit_seen_r;
          hit_seen_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      hit_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      hit_seen_r  <= hit_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    occluded_r <= occluded_nxt;
  end

`include "oriented_rect_occlusion_test_unit_assert.svh"

  `OROT_ASSERT_NXT(a_card_starts_run, cmd.load_card, (state_r == S_RUN) && (step_r == '0), "card did not start program")
  `OROT_ASSERT_NXT(a_emit_clears_hit, (state_r == S_EMIT) && (!out_valid_r || out_ready), out_valid_r && !hit_seen_r, "result not loaded or hit flag kept")
  `OROT_ASSERT_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "result raised outside emit")
  `OROT_ASSERT_NXT(a_run_no_escape, (state_r == S_RUN) && (step_r != STEP_LAST), state_r == S_RUN, "program left early")

endmodule

// ===== rtl/oriented_rect_occlusion_test_unit.sv =====
// ----------------------------------------------------------------------------
// oriented_rect_occlusion_test_unit
// marker: ready again the next cycle unless flagged last, so one per cycle while not last.
// card: accept plus a 32-step program on one shared 27x25 multiplier.
// item flagged last: after the last program step (or the marker) the block enters the
// emit state, which loads the registered result; emit stalls while an older result waits.
// synchronous active-low reset: idle, empty query rectangle, no result pending.
// ----------------------------------------------------------------------------
module oriented_rect_occlusion_test_unit (
  input logic      clk,
  input logic      rst_n,
  orot_in_if.sink  in_ch,
  orot_out_if.source out_ch
);
  import orot_pkg::*;

  in_item_t item;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // gather the request payload
  always_comb begin
    item.req_type       = in_ch.req_type;
    item.center_x       = in_ch.center_x;
    item.center_y       = in_ch.center_y;
    item.size_w         = in_ch.size_w;
    item.size_h         = in_ch.size_h;
    item.angle          = in_ch.angle;
    item.layer_priority = in_ch.layer_priority;
    item.z_order        = in_ch.z_order;
    item.child_index    = in_ch.child_index;
    item.stable_index   = in_ch.stable_index;
    item.last           = in_ch.last;
  end

  orot_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_req_type  (in_ch.req_type),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_occluded (out_ch.occluded),
    .cmd          (cmd),
    .stat         (stat)
  );

  orot_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule

// ===== verif/orot_occlusion_checker.sv =====
// ----------------------------------------------------------------------------
// orot_occlusion_checker
// watches the request and result channels, predicts the occlusion flag of
// each list from the accepted transactions and compares it with the result
// ----------------------------------------------------------------------------
module orot_occlusion_checker (
  input  logic       clk,
  input  logic       rst_n,
  orot_in_if         in_ch,
  orot_out_if        out_ch,
  output int         fail_count,
  output int         pending_count,
  output int         marker_count,
  output int         card_count,
  output int         result_count,
  output int         occluded_count
);
  import orot_pkg::*;

  // quarter-wave sine table, q1.16
  longint sine_tab [0:TRIG_DEPTH];

  // stored marker rectangle and key
  longint      mark_cx, mark_cy, mark_hw, mark_hh, mark_cos, mark_sin;
  logic [63:0] mark_key;
  bit          any_hit;

  // flags still owed by the block
  bit          occluded_queue [$];

  initial begin
    logic [63:0] x, term;
    longint      acc;
    for (int k = 0; k <= TRIG_DEPTH; k++) begin
      x    = (64'(k) * 64'd1686629713) / TRIG_DEPTH;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / (64'(2 * n) * 64'(2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 8192) >>> 14;
      if (acc > 65536) acc = 65536;
      sine_tab[k] = acc;
    end
  end

  // binary angle to cosine and sine by quadrant folding
  task automatic angle_to_axis(input logic [15:0] ang, output longint c, output longint s);
    int     stp, quad, pos;
    longint a, b;
    stp  = int'(ang) >> (16 - TRIG_AW - 2);
    quad = (stp / TRIG_DEPTH) % 4;
    pos  = stp % TRIG_DEPTH;
    a    = sine_tab[pos];
    b    = sine_tab[TRIG_DEPTH - pos];
    case (quad)
      0: begin s = a;  c = b;  end
      1: begin s = b;  c = -a; end
      2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
  endtask

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // rounded magnitude of the dot product of two unit axes
  function automatic longint unit_dot(longint ux, longint uy, longint vx, longint vy);
    return (mag(ux * vx + uy * vy) + 32768) >>> 16;
  endfunction

  // separating-axis test of the stored marker against one card
  function automatic bit boxes_touch(longint cx, longint cy, longint hw, longint hh,
                                     longint c2, longint s2);
    longint axx [4], axy [4];
    longint dx, dy, proj_len, r1, r2;
    if (mark_hw == 0 || mark_hh == 0 || hw == 0 || hh == 0) return 1'b0;
    dx = (cx - mark_cx) * 2;
    dy = (cy - mark_cy) * 2;
    axx[0] = mark_cos;  axy[0] = mark_sin;
    axx[1] = -mark_sin; axy[1] = mark_cos;
    axx[2] = c2;        axy[2] = s2;
    axx[3] = -s2;       axy[3] = c2;
    for (int i = 0; i < 4; i++) begin
      proj_len = mag(dx * axx[i] + dy * axy[i]);
      r1 = unit_dot(axx[0], axy[0], axx[i], axy[i]) * mark_hw
         + unit_dot(axx[1], axy[1], axx[i], axy[i]) * mark_hh;
      r2 = unit_dot(axx[2], axy[2], axx[i], axy[i]) * hw
         + unit_dot(axx[3], axy[3], axx[i], axy[i]) * hh;
      if (proj_len > r1 + r2) return 1'b0;
    end
    return 1'b1;
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    logic [63:0] key;
    longint      c, s;
    bit          want;
    if (!rst_n) begin
      mark_cx = 0; mark_cy = 0; mark_hw = 0; mark_hh = 0;
      mark_cos = 0; mark_sin = 0; mark_key = '0; any_hit = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        key = {in_ch.layer_priority ^ 16'h8000, in_ch.z_order ^ 16'h8000,
               in_ch.child_index, in_ch.stable_index};
        angle_to_axis(in_ch.angle, c, s);
        if (in_ch.req_type == REQ_MARKER) begin
          mark_cx  = longint'(in_ch.center_x);
          mark_cy  = longint'(in_ch.center_y);
          mark_hw  = longint'({1'b0, in_ch.size_w});
          mark_hh  = longint'({1'b0, in_ch.size_h});
          mark_cos = c;
          mark_sin = s;
          mark_key = key;
          any_hit  = 1'b0;
          marker_count++;
        end else begin
          card_count++;
          if (key > mark_key &&
              boxes_touch(longint'(in_ch.center_x), longint'(in_ch.center_y),
                          longint'({1'b0, in_ch.size_w}),
                          longint'({1'b0, in_ch.size_h}), c, s))
            any_hit = 1'b1;
        end
        if (in_ch.last) begin
          occluded_queue.push_back(any_hit);
          any_hit = 1'b0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (occluded_queue.size() == 0) begin
          $error("unexpected result transaction, occluded=%0b", out_ch.occluded);
          fail_count++;
        end else begin
          want = occluded_queue.pop_front();
          if (out_ch.occluded !== want) begin
            $error("field occluded: expected %0b, actual %0b", want, out_ch.occluded);
            fail_count++;
          end
          if (want) occluded_count++;
        end
      end
    end
    pending_count = occluded_queue.size();
  end

  initial begin
    fail_count = 0; pending_count = 0; marker_count = 0;
    card_count = 0; result_count = 0; occluded_count = 0;
  end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives marker and card lists into the occlusion test unit with random
// gaps and result back-pressure; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb;
  import orot_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   fail_count, pending_count, marker_count, card_count;
  int   result_count, occluded_count;
  bit   no_gaps = 1'b0;

  orot_in_if  in_ch ();
  orot_out_if out_ch ();

  oriented_rect_occlusion_test_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  orot_occlusion_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .marker_count   (marker_count),
    .card_count     (card_count),
    .result_count   (result_count),
    .occluded_count (occluded_count)
  );

  always #1 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 1500000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle length: mostly short, a few long, none during quiet stretches
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= (gap_len() == 0);
    end
  end

  // alternate stretches with and without gaps
  initial forever begin
    repeat ($urandom_range(50, 400)) @(negedge clk);
    no_gaps = ($urandom_range(0, 3) == 0);
  end

  function automatic in_item_t rect(logic rt, int cx, int cy, int w, int h, int ang,
                                    int lay, int z, int ch, int st, logic lst);
    in_item_t t;
    t.req_type = rt; t.center_x = cx[23:0]; t.center_y = cy[23:0];
    t.size_w = w[23:0]; t.size_h = h[23:0]; t.angle = ang[15:0];
    t.layer_priority = lay[15:0]; t.z_order = z[15:0];
    t.child_index = ch[15:0]; t.stable_index = st[15:0]; t.last = lst;
    return t;
  endfunction

  // one request transaction, then an optional idle gap
  task automatic send(in_item_t t);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= t.req_type;         in_ch.center_x <= t.center_x;
    in_ch.center_y <= t.center_y;         in_ch.size_w <= t.size_w;
    in_ch.size_h <= t.size_h;             in_ch.angle <= t.angle;
    in_ch.layer_priority <= t.layer_priority; in_ch.z_order <= t.z_order;
    in_ch.child_index <= t.child_index;   in_ch.stable_index <= t.stable_index;
    in_ch.last <= t.last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // key near a base key so that ties and near-ties are common
  function automatic int near_key(int base, int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return base;
    if (r < 8) return base + $urandom_range(0, 2) - 1;
    return $urandom_range(lo, hi);
  endfunction

  in_item_t mk, cd;
  int       n_sent;

  initial begin
    int cnt, w, h, span;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_MARKER; in_ch.center_x <= '0; in_ch.center_y <= '0;
    in_ch.size_w <= '0; in_ch.size_h <= '0; in_ch.angle <= '0;
    in_ch.layer_priority <= '0; in_ch.z_order <= '0; in_ch.child_index <= '0;
    in_ch.stable_index <= '0; in_ch.last <= 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // cards after reset without a marker never hit
    send(rect(REQ_CARD, 0, 0, 25600, 25600, 0, 32767, 0, 0, 0, 1'b1));
    // empty list
    send(rect(REQ_MARKER, 0, 0, 25600, 25600, 0, 0, 0, 0, 0, 1'b1));
    // key ordering: lower, equal, then higher by stable index and by z order
    send(rect(REQ_MARKER, 0, 0, 25600, 25600, 0, 0, 0, 5, 5, 1'b0));
    send(rect(REQ_CARD, 100, 100, 25600, 25600, 0, -1, 0, 5, 5, 1'b0));
    send(rect(REQ_CARD, 100, 100, 25600, 25600, 0, 0, 0, 5, 5, 1'b1));
    send(rect(REQ_MARKER, 0, 0, 25600, 25600, 0, 0, 0, 5, 5, 1'b0));
    send(rect(REQ_CARD, 0, 0, 25600, 25600, 16384, 0, 0, 5, 6, 1'b1));
    send(rect(REQ_MARKER, 0, 0, 25600, 25600, 8192, 0, 0, 5, 5, 1'b0));
    send(rect(REQ_CARD, 25600, 0, 25600, 25600, 32768, 0, 1, 0, 0, 1'b1));
    // zero-size card, then zero-size marker
    send(rect(REQ_MARKER, 0, 0, 25600, 25600, 0, 0, 0, 0, 0, 1'b0));
    send(rect(REQ_CARD, 0, 0, 0, 25600, 0, 1, 0, 0, 0, 1'b0));
    send(rect(REQ_CARD, 0, 0, 25600, 0, 0, 1, 0, 0, 0, 1'b1));
    send(rect(REQ_MARKER, 0, 0, 25600, 0, 0, 0, 0, 0, 0, 1'b0));
    send(rect(REQ_CARD, 0, 0, 25600, 25600, 0, 1, 0, 0, 0, 1'b1));
    // just touching edge, rotated quadrants
    send(rect(REQ_MARKER, 0, 0, 25600, 12800, 49152, 0, 0, 0, 0, 1'b0));
    send(rect(REQ_CARD, 0, 25600, 25600, 25600, 65535, 0, 0, 1, 0, 1'b0));
    send(rect(REQ_CARD, 0, 25601, 25600, 25600, 16384, 0, 0, 1, 0, 1'b1));
    // field extremes
    send(rect(REQ_MARKER, -8388608, -8388608, 16777215, 16777215, 65535,
              -32768, -32768, 0, 0, 1'b0));
    send(rect(REQ_CARD, 8388607, 8388607, 16777215, 16777215, 32768,
              32767, 32767, 65535, 65535, 1'b0));
    send(rect(REQ_CARD, 8388607, -8388608, 1, 1, 0, -32768, -32768, 0, 1, 1'b1));
    // cards after a result reuse the stored marker
    send(rect(REQ_CARD, -8388608, -8388608, 256, 256, 0, 0, 0, 0, 0, 1'b1));
    n_sent = 21;

    // random lists, mostly well-formed with cards around the marker
    while (n_sent < 1250) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: fully random item
        cd = rect($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1));
        send(cd);
        n_sent++;
        continue;
      end
      span = ($urandom_range(0, 9) == 0) ? 8388607 : $urandom_range(64, 16384);
      w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, span);
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, span);
      mk = rect(REQ_MARKER, $urandom_range(0, 2 * span) - span,
                $urandom_range(0, 2 * span) - span, w, h, $urandom,
                $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                $urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
      cnt = $urandom_range(0, 6);
      mk.last = (cnt == 0);
      send(mk);
      n_sent++;
      for (int i = 0; i < cnt; i++) begin
        cd = rect(REQ_CARD,
                  int'(mk.center_x) + $urandom_range(0, 2 * span) - span,
                  int'(mk.center_y) + $urandom_range(0, 2 * span) - span,
                  ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, span),
                  ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, span),
                  $urandom,
                  near_key(int'(mk.layer_priority), -32768, 32767),
                  near_key(int'(mk.z_order), -32768, 32767),
                  near_key(int'(mk.child_index), 0, 65535),
                  near_key(int'(mk.stable_index), 0, 65535),
                  i == cnt - 1);
        send(cd);
        n_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for a card still in flight
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d markers and %0d cards in %0d lists, %0d of them occluded",
             marker_count, card_count, result_count, occluded_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/orot_pkg.sv
rtl/orot_in_if.sv
rtl/orot_out_if.sv
rtl/orot_datapath.sv
rtl/orot_ctrl.sv
rtl/oriented_rect_occlusion_test_unit.sv
verif/orot_occlusion_checker.sv
verif/tb.sv
